>>> rtl/scope_capture_pingpong_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Scope capture framer assertion macros
// Shared concurrent check wrappers for the capture framer RTL.
// ----------------------------------------------------------------------------
`ifndef SCOPE_CAPTURE_PINGPONG_FRAMER_CORE_MACROS_SVH
`define SCOPE_CAPTURE_PINGPONG_FRAMER_CORE_MACROS_SVH

// check with reset masking
`define SCPF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is applied
`define SCPF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// Scope capture framer package
// Shared types and codes for the capture store, frame emitter and core.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int WORD_W     = 32;
  localparam int SEQ_W      = 16;
  localparam int IN_SAMPLES = 4;
  localparam int CFG_IDX_W  = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_SEND    = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 2'd0,
    REG_CHANNEL_MASK = 2'd1,
    REG_HEADER_MAGIC = 2'd2,
    REG_FOOTER_MAGIC = 2'd3
  } cfg_reg_t;

  // frame start request from the core to the emitter
  typedef struct packed {
    logic start;
    seq_t seq;
  } launch_t;

endpackage

>>> rtl/scpf_store.sv
// ----------------------------------------------------------------------------
// Scope capture sample store
// Two-bank frame memory, one row per frame, one write and one registered read.
// ----------------------------------------------------------------------------
module scpf_store #(
  parameter int NUM_CHANNELS = 4,
  parameter int ADDR_W       = 5
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [ADDR_W-1:0]                          wr_addr,
  input  logic [NUM_CHANNELS-1:0][scpf_pkg::WORD_W-1:0] wr_row,
  input  logic                                       rd_en,
  input  logic [ADDR_W-1:0]                          rd_addr,
  output logic [NUM_CHANNELS-1:0][scpf_pkg::WORD_W-1:0] rd_row
);
  import scpf_pkg::*;

  localparam int ROW_W = NUM_CHANNELS * WORD_W;

  logic [ROW_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/scpf_framer.sv
// ----------------------------------------------------------------------------
// Scope capture frame emitter
// Serializes one frame (header, sequence/count, channels, footer) per start.
// ----------------------------------------------------------------------------
module scpf_framer #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  scpf_pkg::launch_t                             launch,
  input  logic [NUM_CHANNELS-1:0][scpf_pkg::WORD_W-1:0] row,
  input  scpf_pkg::word_t                               header_magic,
  input  scpf_pkg::word_t                               footer_magic,
  output logic                                          busy,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output scpf_pkg::word_t                               frame_word,
  output logic                                          last_word
);
  import scpf_pkg::*;

  localparam int NUM_WORDS = NUM_CHANNELS + 3;
  localparam int CNT_W     = $clog2(NUM_WORDS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_WORDS - 1);

  logic [CNT_W-1:0] cnt;
  seq_t             seq;
  logic             load;
  word_t            word_next;

  assign load = busy && (!out_valid || !out_stall);

  always_comb begin
    word_next = footer_magic;
    if (cnt == '0) begin
      word_next = header_magic;
    end else if (cnt == CNT_W'(1)) begin
      word_next = {(WORD_W - SEQ_W)'(NUM_CHANNELS), seq};
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cnt == CNT_W'(i + 2)) begin
          word_next = row[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (launch.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (load) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch.start) begin
      seq <= launch.seq;
    end
    if (load) begin
      frame_word <= word_next;
      last_word  <= (cnt == LAST_CNT);
    end
  end

endmodule

>>> rtl/scope_capture_pingpong_framer_core.sv
// ----------------------------------------------------------------------------
// Scope capture ping-pong framer core
// Two-bank capture store with a framed word output for filled banks.
//
// Input channel (in_valid/in_stall): one request per item. A capture request
// (opcode 0) writes one masked row into the current bank and gives no
// output; captures are ignored while disabled. A send request (opcode 1)
// walks the last filled bank one frame per request.
// Output channel (out_valid/out_stall): an emitted frame is NUM_CHANNELS + 3
// words, the footer flagged by last_word. A taken send request launches the
// emitter, which then registers one word per cycle while not stalled.
// Throughput: one capture or skipped send per cycle while the emitter is idle.
// While a frame is being serialized in_stall is high, so the next request
// waits until the emitter has loaded the footer into its output register.
// A receiver stall holds the current word and, through the emitter, stalls
// the input. Reset (rst, synchronous) clears control state and configuration
// registers; the sample store is not cleared, a walk only reads filled banks.
// Configuration writes are taken at any cycle with cfg_wr_en high outside reset.
// ----------------------------------------------------------------------------
`include "scope_capture_pingpong_framer_core_macros.svh"

module scope_capture_pingpong_framer_core #(
  parameter int NUM_CHANNELS = 4,
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  scpf_pkg::word_t                cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic                           tx_allowed,
  input  logic signed [31:0]             sample_0,
  input  logic signed [31:0]             sample_1,
  input  logic signed [31:0]             sample_2,
  input  logic signed [31:0]             sample_3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scpf_pkg::word_t                frame_word,
  output logic                           last_word
);
  import scpf_pkg::*;

  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

  // configuration
  logic        enable;
  logic [3:0]  channel_mask;
  word_t       header_magic;
  word_t       footer_magic;

  // control state
  logic             write_bank;
  logic [IDX_W-1:0] write_index;
  logic             send_bank;
  logic [IDX_W-1:0] read_index;
  logic             reading;
  logic             send_pending;
  seq_t             sequence_number;

  logic                                 in_acc;
  logic                                 send_acc;
  logic                                 cap_acc;
  logic                                 cap;
  logic                                 tick;
  logic                                 walk_bank;
  logic [IDX_W-1:0]                     walk_index;
  logic                                 emit;
  logic [IN_SAMPLES-1:0][WORD_W-1:0]    smp;
  logic [NUM_CHANNELS-1:0][WORD_W-1:0]  wr_row;
  logic [NUM_CHANNELS-1:0][WORD_W-1:0]  rd_row;
  launch_t                              launch;
  logic                                 fr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      channel_mask <= '0;
      header_magic <= '0;
      footer_magic <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_CHANNEL_MASK: channel_mask <= cfg_data[3:0];
        REG_HEADER_MAGIC: header_magic <= cfg_data;
        REG_FOOTER_MAGIC: footer_magic <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall   = fr_busy;
  assign in_acc     = in_valid && !in_stall;
  assign send_acc   = in_acc && (opcode == OP_SEND);
  assign cap_acc    = in_acc && (opcode == OP_CAPTURE);
  assign cap        = cap_acc && enable;
  assign tick       = send_acc && (reading || send_pending);
  assign walk_bank  = reading ? send_bank : ~write_bank;
  assign walk_index = reading ? read_index : '0;
  assign emit       = tick && tx_allowed;

  assign smp = {sample_3, sample_2, sample_1, sample_0};

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      wr_row[i] = '0;
      if (i < IN_SAMPLES) begin
        if (channel_mask[2'(i)]) begin
          wr_row[i] = smp[2'(i)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank      <= 1'b1;
      write_index     <= '0;
      send_bank       <= 1'b0;
      read_index      <= '0;
      reading         <= 1'b0;
      send_pending    <= 1'b0;
      sequence_number <= '0;
    end else begin
      if (cap) begin
        if (write_index == LAST_IDX) begin
          write_index  <= '0;
          write_bank   <= ~write_bank;
          send_pending <= 1'b1;
        end else begin
          write_index <= write_index + IDX_W'(1);
        end
      end
      if (tick) begin
        if (!reading) begin
          send_pending <= 1'b0;
          send_bank    <= walk_bank;
        end
        if (walk_index == LAST_IDX) begin
          read_index <= '0;
          reading    <= 1'b0;
        end else begin
          read_index <= walk_index + IDX_W'(1);
          reading    <= 1'b1;
        end
        if (tx_allowed) begin
          sequence_number <= sequence_number + SEQ_W'(1);
        end
      end
    end
  end

  assign launch.start = emit;
  assign launch.seq   = sequence_number;

  scpf_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ADDR_W       (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (cap),
    .wr_addr ({write_bank, write_index}),
    .wr_row  (wr_row),
    .rd_en   (emit),
    .rd_addr ({walk_bank, walk_index}),
    .rd_row  (rd_row)
  );

  scpf_framer #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_framer (
    .clk          (clk),
    .rst          (rst),
    .launch       (launch),
    .row          (rd_row),
    .header_magic (header_magic),
    .footer_magic (footer_magic),
    .busy         (fr_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_word   (frame_word),
    .last_word    (last_word)
  );

  `SCPF_CHECK(a_skip_no_frame, (send_acc && !tx_allowed) |=> !fr_busy, "skip started a frame")
  `SCPF_CHECK(a_capture_no_frame, cap_acc |=> !fr_busy, "capture started a frame")
  `SCPF_CHECK(a_walk_clears_pending, (tick && !reading) |=> !send_pending, "pending not cleared")
  `SCPF_CHECK(a_index_range, write_index <= LAST_IDX && read_index <= LAST_IDX, "bad index")
  `SCPF_CHECK_ALWAYS(a_reset_idle, rst |=> !out_valid && !fr_busy, "busy after reset")

endmodule
